FILE: rtl/core/bhps_pkg.sv
// Shared types, constants and command codes for the binary heap priority store.
package bhps_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CMD_W = 3;
	localparam int DATA_W = 32;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SORT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0] index;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0] element_count;
		logic [STAT_W-1:0] status;
	} out_item_t;
endpackage

FILE: rtl/core/binary_heap_priority_store_top.sv
// Top level: heap command sequencer around the element store.
// Clear, load and unused codes go straight to the result; read passes through S_RD;
// insert moves up one level per S_UPA/S_UPB pass and finishes in S_UPC;
// build and sort sift down through S_DNA to S_DNE, and sort swaps via S_SWA to S_SWC.
// One item at a time; the result waits in an output register and a new item
// is taken once it leaves. Reset (arst_n low) clears count, order_q and control.
module binary_heap_priority_store_top import bhps_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);
	localparam int AW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1) + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_UPA = 4'd2;
	localparam logic [3:0] S_UPB = 4'd3;
	localparam logic [3:0] S_UPC = 4'd4;
	localparam logic [3:0] S_DNA = 4'd5;
	localparam logic [3:0] S_DNB = 4'd6;
	localparam logic [3:0] S_DNC = 4'd7;
	localparam logic [3:0] S_DND = 4'd8;
	localparam logic [3:0] S_DNE = 4'd9;
	localparam logic [3:0] S_NEXT = 4'd10;
	localparam logic [3:0] S_SWA = 4'd11;
	localparam logic [3:0] S_SWB = 4'd12;
	localparam logic [3:0] S_SWC = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q;
	logic order_q;
	logic [NW-1:0] count_q, n_q, pos_q, bi_q, lim_q;
	logic sorting_q;
	logic sink_q;
	logic [VALUE_WIDTH-1:0] cur_q, rv_q;
	logic [STAT_W-1:0] stat_q;
	logic [DATA_W-1:0] rdat_q;
	logic [IDX_W-1:0] idx_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata, rdata;

	bhps_mem #(.DEPTH(CAPACITY), .WIDTH(VALUE_WIDTH), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic above(input logic mn, input logic [VALUE_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] b);
		above = mn ? (a < b) : (a > b);
	endfunction

	logic [NW-1:0] rc, lc, par;
	assign rc = (pos_q << 1) + NW'(2);
	assign lc = (pos_q << 1) + NW'(1);
	assign par = (pos_q - NW'(1)) >> 1;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = cur_q;
		raddr = '0;
		case (state_q)
			S_IDLE: raddr = AW'(in_data.index);
			S_UPA: begin
				raddr = AW'(par);
				if (pos_q == '0) begin
					we = 1'b1; waddr = '0; wdata = cur_q;
				end
			end
			S_UPB: begin
				if (above(order_q, cur_q, rdata)) begin
					we = 1'b1; waddr = AW'(pos_q); wdata = rdata;
				end else begin
					we = 1'b1; waddr = AW'(pos_q); wdata = cur_q;
				end
			end
			S_DNA: raddr = AW'(pos_q);
			S_DNB: raddr = AW'(rc);
			S_DNC: raddr = AW'(lc);
			S_DNE: begin
				we = 1'b1; waddr = AW'(pos_q); wdata = rv_q;
			end
			S_SWA: raddr = '0;
			S_SWB: raddr = AW'(lim_q);
			S_SWC: begin
				we = 1'b1; waddr = AW'(lim_q); wdata = cur_q;
			end
			default: ;
		endcase
		if (state_q == S_IDLE && in_valid && in_ready &&
			(in_data.command == CMD_LOAD || in_data.command == CMD_INSERT) &&
			count_q < NW'(CAPACITY)) begin
			we = 1'b1; waddr = AW'(count_q); wdata = VALUE_WIDTH'(in_data.value);
		end
	end

	// rv_q: value of the chosen child; cur_q: value being moved
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_q <= 1'b0;
			count_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			sorting_q <= 1'b0;
			sink_q <= 1'b0;
			cur_q <= '0; rv_q <= '0;
			stat_q <= ST_OK; rdat_q <= '0; idx_q <= '0;
			n_q <= '0; pos_q <= '0; bi_q <= '0; lim_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) order_q <= cfg_data;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						idx_q <= in_data.index;
						cur_q <= VALUE_WIDTH'(in_data.value);
						stat_q <= ST_OK;
						rdat_q <= '0;
						state_q <= S_DONE;
						case (in_data.command)
							CMD_CLEAR: count_q <= '0;
							CMD_LOAD: begin
								if (count_q < NW'(CAPACITY)) count_q <= count_q + NW'(1);
								else stat_q <= ST_FULL;
							end
							CMD_INSERT: begin
								if (count_q < NW'(CAPACITY)) begin
									pos_q <= count_q;
									state_q <= S_UPA;
								end else stat_q <= ST_FULL;
							end
							CMD_BUILD, CMD_SORT: begin
								if (count_q > NW'(1)) begin
									n_q <= count_q;
									bi_q <= count_q >> 1;
									sorting_q <= (in_data.command == CMD_SORT);
									lim_q <= count_q - NW'(1);
									state_q <= S_NEXT;
								end
							end
							CMD_READ: state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (NW'(idx_q) < count_q) rdat_q <= DATA_W'(rdata);
					else stat_q <= ST_RANGE;
					state_q <= S_DONE;
				end
				S_UPA: begin
					if (pos_q == '0) state_q <= S_UPC;
					else state_q <= S_UPB;
				end
				S_UPB: begin
					if (above(order_q, cur_q, rdata)) begin
						pos_q <= par;
						state_q <= S_UPA;
					end else state_q <= S_UPC;
				end
				S_UPC: begin
					count_q <= count_q + NW'(1);
					state_q <= S_DONE;
				end
				S_NEXT: begin
					if (bi_q != '0) begin
						pos_q <= bi_q - NW'(1);
						bi_q <= bi_q - NW'(1);
						state_q <= S_DNA;
					end else if (sorting_q && n_q > NW'(1)) begin
						state_q <= S_SWA;
					end else state_q <= S_DONE;
				end
				S_DNA: state_q <= S_DNB;
				S_DNB: begin
					if (!sink_q) begin
						cur_q <= rdata;
						rv_q <= rdata;
					end
					sink_q <= 1'b0;
					state_q <= S_DNC;
				end
				S_DNC: begin
					// rdata holds right child
					if (rc < n_q && above(order_q, rdata, rv_q)) begin
						rv_q <= rdata; lim_q <= rc;
					end else lim_q <= pos_q;
					state_q <= S_DND;
				end
				S_DND: begin
					if (lc < n_q && above(order_q, rdata, rv_q)) begin
						rv_q <= rdata; lim_q <= lc;
					end
					state_q <= S_DNE;
				end
				S_DNE: begin
					if (lim_q == pos_q) begin
						state_q <= S_NEXT;
						lim_q <= n_q - NW'(1);
					end else begin
						pos_q <= lim_q;
						rv_q <= cur_q;
						sink_q <= 1'b1;
						state_q <= S_DNA;
					end
				end
				S_SWA: state_q <= S_SWB;
				S_SWB: begin
					cur_q <= rdata;
					state_q <= S_SWC;
				end
				S_SWC: begin
					// sift the last element down from the root
					cur_q <= rdata;
					rv_q <= rdata;
					sink_q <= 1'b1;
					n_q <= n_q - NW'(1);
					pos_q <= '0;
					state_q <= S_DNA;
					lim_q <= n_q - NW'(2);
				end
				S_DONE: begin
					if (!out_valid) begin
						out_data.read_data <= rdat_q;
						out_data.element_count <= CNT_W'(count_q);
						out_data.status <= stat_q;
						out_valid <= 1'b1;
						sorting_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(CAPACITY)) else $error("count over capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid) else $error("accept with result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("ready while busy");
endmodule

FILE: rtl/core/bhps_mem.sv
// Element store: single-port-write, single-read synchronous memory.
module bhps_mem import bhps_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = VALUE_WIDTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
